FILE: rtl/brm_pkg.sv
package brm_pkg;

  // Magnitude of a scaled root part, Q18.30.
  localparam int MAG_W  = 48;
  localparam int HALF_W = 24;
  // Squared magnitudes and numerators, 60 fraction bits.
  localparam int DEN_W  = 98;
  // Dividend and remainder of the quotient divider.
  localparam int REM_W  = 128;
  // Compare width: the divisor shifted by the top quotient bit.
  localparam int CMP_W  = 131;
  // Quotient bits produced, from bit 32 down to bit 0.
  localparam int QBITS  = 33;

  localparam logic [31:0] SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG   = 32'h8000_0000;
  localparam logic [31:0] MINUS_ONE = 32'hC000_0000;

  // Sideband that rides with a root down the divider.
  typedef struct packed {
    logic inf;
    logic dzero;
    logic neg_r;
    logic neg_i;
  } flags_t;

endpackage

FILE: rtl/brm_ifs.sv
interface root_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] root_real;
  logic signed [31:0] root_imag;
  logic               root_at_infinity;
  logic               root_is_zero;

  modport source (output valid, root_real, root_imag, root_at_infinity, root_is_zero,
                  input ready);
  modport sink (input valid, root_real, root_imag, root_at_infinity, root_is_zero,
                output ready);
endinterface

interface zroot_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] digital_real;
  logic signed [31:0] digital_imag;
  logic               overflow;

  modport source (output valid, digital_real, digital_imag, overflow, input ready);
  modport sink (input valid, digital_real, digital_imag, overflow, output ready);
endinterface

FILE: rtl/brm_scale.sv
module brm_scale
  import brm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_in,
  input  logic signed [31:0] root_real,
  input  logic signed [31:0] root_imag,
  input  logic               inf_in,
  input  logic [31:0]        hsp,
  output logic               vld_out,
  output logic [MAG_W-1:0]   mag_c,
  output logic [MAG_W-1:0]   mag_zr,
  output logic [MAG_W-1:0]   mag_zi,
  output logic               neg_zi,
  output logic               inf_out
);

  localparam logic signed [49:0] ONE_Q30 = 50'sd1 <<< 30;

  logic               vld1;
  logic               inf1;
  logic signed [64:0] mr;
  logic signed [64:0] mi;
  logic signed [64:0] sum_r;
  logic signed [64:0] sum_i;
  logic signed [48:0] zr;
  logic signed [48:0] zi;
  logic signed [49:0] c;

  // First stage: z = T * s with 46 fraction bits.
  always_ff @(posedge clk) begin
    if (en) begin
      mr   <= root_real * $signed({1'b0, hsp});
      mi   <= root_imag * $signed({1'b0, hsp});
      inf1 <= inf_in;
    end
  end

  // Round half up to 30 fraction bits and form 1 - zr.
  always_comb begin
    sum_r = mr + 65'sd32768;
    sum_i = mi + 65'sd32768;
    zr    = sum_r[64:16];
    zi    = sum_i[64:16];
    c     = ONE_Q30 - {zr[48], zr};
  end

  // Second stage: magnitudes for the squarers.
  always_ff @(posedge clk) begin
    if (en) begin
      mag_c   <= c[49] ? MAG_W'(-c) : MAG_W'(c);
      mag_zr  <= zr[48] ? MAG_W'(-zr) : MAG_W'(zr);
      mag_zi  <= zi[48] ? MAG_W'(-zi) : MAG_W'(zi);
      neg_zi  <= zi[48];
      inf_out <= inf1;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld1    <= vld_in;
      vld_out <= vld1;
    end
  end

endmodule

FILE: rtl/brm_square.sv
module brm_square
  import brm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_in,
  input  logic [MAG_W-1:0] mag_c,
  input  logic [MAG_W-1:0] mag_zr,
  input  logic [MAG_W-1:0] mag_zi,
  input  logic             neg_zi,
  input  logic             inf_in,
  output logic             vld_out,
  output logic [DEN_W-1:0] den,
  output logic [DEN_W-1:0] num_r,
  output logic [DEN_W-1:0] num_i,
  output flags_t           flg
);

  localparam logic [DEN_W-1:0] ONE_Q60 = DEN_W'(1) << 60;

  logic                vld3;
  logic                neg3;
  logic                inf3;
  logic [MAG_W-1:0]    zi3;
  logic [2*HALF_W-1:0] c_hh, c_hl, c_ll;
  logic [2*HALF_W-1:0] r_hh, r_hl, r_ll;
  logic [2*HALF_W-1:0] i_hh, i_hl, i_ll;
  logic [DEN_W-1:0]    sq_c, sq_r, sq_i;
  logic [DEN_W-1:0]    d_sum, p_sum;

  function automatic logic [DEN_W-1:0] join_sq(input logic [2*HALF_W-1:0] hh,
                                               input logic [2*HALF_W-1:0] hl,
                                               input logic [2*HALF_W-1:0] ll);
    join_sq = (DEN_W'(hh) << (2 * HALF_W)) + (DEN_W'(hl) << (HALF_W + 1)) + DEN_W'(ll);
  endfunction

  // Third stage: each 48-bit square as three 24 by 24 partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      c_hh <= mag_c[MAG_W-1:HALF_W] * mag_c[MAG_W-1:HALF_W];
      c_hl <= mag_c[MAG_W-1:HALF_W] * mag_c[HALF_W-1:0];
      c_ll <= mag_c[HALF_W-1:0] * mag_c[HALF_W-1:0];
      r_hh <= mag_zr[MAG_W-1:HALF_W] * mag_zr[MAG_W-1:HALF_W];
      r_hl <= mag_zr[MAG_W-1:HALF_W] * mag_zr[HALF_W-1:0];
      r_ll <= mag_zr[HALF_W-1:0] * mag_zr[HALF_W-1:0];
      i_hh <= mag_zi[MAG_W-1:HALF_W] * mag_zi[MAG_W-1:HALF_W];
      i_hl <= mag_zi[MAG_W-1:HALF_W] * mag_zi[HALF_W-1:0];
      i_ll <= mag_zi[HALF_W-1:0] * mag_zi[HALF_W-1:0];
      zi3  <= mag_zi;
      neg3 <= neg_zi;
      inf3 <= inf_in;
    end
  end

  // Sum the partial products into |1-z|^2 and |z|^2.
  always_comb begin
    sq_c  = join_sq(c_hh, c_hl, c_ll);
    sq_r  = join_sq(r_hh, r_hl, r_ll);
    sq_i  = join_sq(i_hh, i_hl, i_ll);
    d_sum = sq_c + sq_i;
    p_sum = sq_r + sq_i;
  end

  // Fourth stage: denominator and numerator magnitudes with signs.
  always_ff @(posedge clk) begin
    if (en) begin
      den       <= d_sum;
      num_r     <= (p_sum <= ONE_Q60) ? ONE_Q60 - p_sum : p_sum - ONE_Q60;
      num_i     <= DEN_W'(zi3) << 31;
      flg.inf   <= inf3;
      flg.dzero <= (d_sum == '0);
      flg.neg_r <= (p_sum > ONE_Q60);
      flg.neg_i <= neg3;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld3    <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld3    <= vld_in;
      vld_out <= vld3;
    end
  end

endmodule

FILE: rtl/brm_divider.sv
module brm_divider
  import brm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_in,
  input  logic [DEN_W-1:0] den_in,
  input  logic [DEN_W-1:0] num_r,
  input  logic [DEN_W-1:0] num_i,
  input  flags_t           flg_in,
  output logic             vld_out,
  output logic [QBITS-1:0] q_r,
  output logic [QBITS-1:0] q_i,
  output logic             sat_r,
  output logic             sat_i,
  output flags_t           flg_out
);

  // One pipeline stage per quotient bit, after the setup stage.
  localparam int NST = QBITS + 1;

  logic             vld  [NST];
  logic [REM_W-1:0] rem_r[NST];
  logic [REM_W-1:0] rem_i[NST];
  logic [QBITS-1:0] qr   [NST];
  logic [QBITS-1:0] qi   [NST];
  logic             sr   [NST];
  logic             si   [NST];
  logic [DEN_W-1:0] den  [NST];
  flags_t           flg  [NST];

  logic [REM_W-1:0] init_r;
  logic [REM_W-1:0] init_i;
  logic [CMP_W-1:0] den_top;

  // Setup: dividend num * 2^30 plus half the divisor for rounding.
  always_comb begin
    init_r  = (REM_W'(num_r) << 30) + REM_W'(den_in >> 1);
    init_i  = (REM_W'(num_i) << 30) + REM_W'(den_in >> 1);
    den_top = CMP_W'(den_in) << QBITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= init_r;
      rem_i[0] <= init_i;
      qr[0]    <= '0;
      qi[0]    <= '0;
      sr[0]    <= (CMP_W'(init_r) >= den_top);
      si[0]    <= (CMP_W'(init_i) >= den_top);
      den[0]   <= den_in;
      flg[0]   <= flg_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_in;
    end
  end

  // Restoring steps, quotient bit 32 first.
  for (genvar k = 1; k < NST; k++) begin : g_step
    localparam int B = QBITS - k;
    logic [CMP_W-1:0] dsh;
    logic             take_r;
    logic             take_i;

    always_comb begin
      dsh    = CMP_W'(den[k-1]) << B;
      take_r = (CMP_W'(rem_r[k-1]) >= dsh);
      take_i = (CMP_W'(rem_i[k-1]) >= dsh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take_r ? rem_r[k-1] - dsh[REM_W-1:0] : rem_r[k-1];
        rem_i[k] <= take_i ? rem_i[k-1] - dsh[REM_W-1:0] : rem_i[k-1];
        qr[k]    <= qr[k-1] | (QBITS'(take_r) << B);
        qi[k]    <= qi[k-1] | (QBITS'(take_i) << B);
        sr[k]    <= sr[k-1];
        si[k]    <= si[k-1];
        den[k]   <= den[k-1];
        flg[k]   <= flg[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  assign vld_out = vld[NST-1];
  assign q_r     = qr[NST-1];
  assign q_i     = qi[NST-1];
  assign sat_r   = sr[NST-1];
  assign sat_i   = si[NST-1];
  assign flg_out = flg[NST-1];

endmodule

FILE: rtl/bilinear_root_mapper_core.sv
// Bilinear root mapper: maps an analog root s to w = (1 + Ts) / (1 - Ts).
// Input channel "roots" carries root_real/root_imag (signed Q18.14) and the
// root_at_infinity and root_is_zero flags; a beat moves on valid && ready.
// Output channel "zroots" carries digital_real/digital_imag (signed Q2.30)
// and overflow, set when a part saturated or the denominator was zero.
// The scale T (unsigned Q0.32) resets to zero and is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce. A root passes the scaling multiply
// and rounding, the squarers, the divider setup, the one-bit-per-stage
// restoring divider and the output register. Throughput is one root per
// cycle while no result waits on a stalled receiver.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and roots.ready drops; nothing is lost or repeated.
// Reset is synchronous and clears every valid bit and the scale register.
module bilinear_root_mapper_core
  import brm_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  root_if.sink           roots,
  zroot_if.source        zroots
);

  logic             en;
  logic [31:0]      hsp;
  logic             s_vld;
  logic [MAG_W-1:0] mag_c, mag_zr, mag_zi;
  logic             neg_zi, s_inf;
  logic             q_vld;
  logic [DEN_W-1:0] den, num_r, num_i;
  flags_t           q_flg;
  logic             d_vld;
  logic [QBITS-1:0] q_r, q_i;
  logic             sat_r, sat_i;
  flags_t           d_flg;
  logic [31:0]      res_r, res_i;
  logic             of_r, of_i;
  logic             out_vld;

  // Apply sign and range to a quotient.
  function automatic logic [32:0] finish(input logic [QBITS-1:0] q,
                                         input logic neg, input logic sat);
    logic [32:0] r;
    if (sat) begin
      r = {1'b1, neg ? SAT_NEG : SAT_POS};
    end else if (!neg) begin
      r = (q > QBITS'(SAT_POS)) ? {1'b1, SAT_POS} : {1'b0, q[31:0]};
    end else begin
      r = (q > QBITS'(SAT_NEG)) ? {1'b1, SAT_NEG} : {1'b0, 32'(-q)};
    end
    finish = r;
  endfunction

  // The whole pipeline advances unless a result waits on a stalled receiver.
  assign en          = !out_vld || zroots.ready;
  assign roots.ready = en;

  // Scale register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hsp <= '0;
    end else if (cfg_we) begin
      hsp <= cfg_wdata;
    end
  end

  brm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .vld_in    (roots.valid),
    .root_real (roots.root_real),
    .root_imag (roots.root_imag),
    .inf_in    (roots.root_at_infinity),
    .hsp       (hsp),
    .vld_out   (s_vld),
    .mag_c     (mag_c),
    .mag_zr    (mag_zr),
    .mag_zi    (mag_zi),
    .neg_zi    (neg_zi),
    .inf_out   (s_inf)
  );

  brm_square u_square (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (s_vld),
    .mag_c   (mag_c),
    .mag_zr  (mag_zr),
    .mag_zi  (mag_zi),
    .neg_zi  (neg_zi),
    .inf_in  (s_inf),
    .vld_out (q_vld),
    .den     (den),
    .num_r   (num_r),
    .num_i   (num_i),
    .flg     (q_flg)
  );

  brm_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (q_vld),
    .den_in  (den),
    .num_r   (num_r),
    .num_i   (num_i),
    .flg_in  (q_flg),
    .vld_out (d_vld),
    .q_r     (q_r),
    .q_i     (q_i),
    .sat_r   (sat_r),
    .sat_i   (sat_i),
    .flg_out (d_flg)
  );

  // Final selection of special cases.
  always_comb begin
    {of_r, res_r} = finish(q_r, d_flg.neg_r, sat_r);
    {of_i, res_i} = finish(q_i, d_flg.neg_i, sat_i);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (d_flg.inf) begin
        zroots.digital_real <= MINUS_ONE;
        zroots.digital_imag <= '0;
        zroots.overflow     <= 1'b0;
      end else if (d_flg.dzero) begin
        zroots.digital_real <= SAT_POS;
        zroots.digital_imag <= '0;
        zroots.overflow     <= 1'b1;
      end else begin
        zroots.digital_real <= res_r;
        zroots.digital_imag <= res_i;
        zroots.overflow     <= of_r | of_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= d_vld;
    end
  end

  assign zroots.valid = out_vld;

endmodule

FILE: dv/tb_bilinear_root_mapper_core.sv
module tb_bilinear_root_mapper_core
  import brm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 39;
  localparam int STALL_LIMIT  = 20000;
  localparam logic [31:0] SCALE_HALF = 32'h8000_0000;

  // One mapped z-plane root.
  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ovf;
  } zroot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  root_if  roots ();
  zroot_if zroots ();

  zroot_t      mapped_q[$];
  logic [31:0] scale;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  bilinear_root_mapper_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .roots     (roots.sink),
    .zroots    (zroots.source)
  );

  always #2 clk = ~clk;

  initial begin
    roots.valid            = 1'b0;
    roots.root_real        = '0;
    roots.root_imag        = '0;
    roots.root_at_infinity = 1'b0;
    roots.root_is_zero     = 1'b0;
    zroots.ready           = 1'b0;
  end

  function automatic logic [127:0] mag66(input logic signed [65:0] x);
    logic [65:0] u;
    u = (x < 0) ? 66'(-x) : 66'(x);
    return 128'(u);
  endfunction

  // Rounded |num| * 2^30 / den with sign, saturated to 32 bits.
  function automatic logic [31:0] quotient_q30(input logic [127:0] num, input logic neg,
                                               input logic [127:0] den, inout logic sat);
    logic [191:0] rem;
    logic [191:0] q;
    rem = (192'(num) << 30) + 192'(den >> 1);
    q = rem / 192'(den);
    if (!neg) begin
      if (q > 192'h7FFF_FFFF) begin
        sat = 1'b1;
        return SAT_POS;
      end
      return q[31:0];
    end
    if (q > 192'h8000_0000) begin
      sat = 1'b1;
      return SAT_NEG;
    end
    return 32'(-q[31:0]);
  endfunction

  // Bilinear map w = (1 + z) / (1 - z) with z = scale * s.
  function automatic zroot_t map_root(input logic signed [31:0] sr, input logic signed [31:0] si,
                                      input logic at_inf, input logic [31:0] h);
    logic signed [65:0] zr, zi, c;
    logic [127:0] den, p, nr, ni;
    logic neg_r, sat;
    zroot_t r;
    sat = 1'b0;
    if (at_inf) begin
      r.re = MINUS_ONE;
      r.im = '0;
      r.ovf = 1'b0;
      return r;
    end
    zr = (66'(sr) * $signed({34'd0, h}) + 66'sd32768) >>> 16;
    zi = (66'(si) * $signed({34'd0, h}) + 66'sd32768) >>> 16;
    c = (66'sd1 <<< 30) - zr;
    den = mag66(c) * mag66(c) + mag66(zi) * mag66(zi);
    if (den == 0) begin
      r.re = SAT_POS;
      r.im = '0;
      r.ovf = 1'b1;
      return r;
    end
    p = mag66(zr) * mag66(zr) + mag66(zi) * mag66(zi);
    neg_r = p > (128'd1 << 60);
    nr = neg_r ? p - (128'd1 << 60) : (128'd1 << 60) - p;
    ni = mag66(zi) << 31;
    r.re = quotient_q30(nr, neg_r, den, sat);
    r.im = quotient_q30(ni, zi < 0, den, sat);
    r.ovf = sat;
    return r;
  endfunction

  // Send one root, with bursts of back-to-back beats separated by random gaps.
  task automatic send_root(input logic signed [31:0] sr, input logic signed [31:0] si,
                           input logic at_inf, input logic is_zero);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        roots.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    roots.valid            <= 1'b1;
    roots.root_real        <= sr;
    roots.root_imag        <= si;
    roots.root_at_infinity <= at_inf;
    roots.root_is_zero     <= is_zero;
    do @(posedge clk); while (!roots.ready);
    mapped_q.push_back(map_root(sr, si, at_inf, scale));
  endtask

  // Let the pipeline drain before touching the scale register.
  task automatic drain();
    roots.valid <= 1'b0;
    burst_left = 0;
    wait (mapped_q.size() == 0);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_scale(input logic [31:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scale = v;
  endtask

  // Real and imaginary parts spread over many magnitudes.
  function automatic logic signed [31:0] rand_part();
    logic signed [31:0] v;
    v = $signed($urandom());
    if ($urandom_range(0, 3) != 0) v = v >>> $urandom_range(0, 31);
    return v;
  endfunction

  task automatic test_special_cases();
    // Reset scale: z is zero, every finite root maps to +1.
    send_root(32'sd16384, -32'sd16384, 1'b0, 1'b0);
    send_root(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b1);
    write_scale(SCALE_HALF);
    // At infinity, pole and zero, with junk in the parts.
    send_root(32'sh1234_5678, -32'sd77, 1'b1, 1'b0);
    send_root(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1);
    // z exactly 1 gives a zero denominator.
    send_root(32'sd32768, 32'sd0, 1'b0, 1'b0);
    send_root(32'sd32768, 32'sd0, 1'b0, 1'b1);
    // Near z = 1: saturation in both parts.
    send_root(32'sd32767, 32'sd1, 1'b0, 1'b0);
    send_root(32'sd32769, -32'sd1, 1'b0, 1'b0);
    // Origin, the field extremes, pure imaginary and negative real.
    send_root(32'sd0, 32'sd0, 1'b0, 1'b0);
    send_root(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    send_root(32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b1);
    send_root(32'sd0, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    send_root(-32'sd16384, 32'sd0, 1'b0, 1'b0);
    write_scale(32'hFFFF_FFFF);
    send_root(32'sd16384, 32'sd0, 1'b0, 1'b0);
    send_root(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b1);
    send_root(-32'sd1, 32'sd1, 1'b0, 1'b0);
  endtask

  // Random roots under one scale; some aimed near z = 1 where division is hard.
  task automatic test_random_roots(input logic [31:0] h, input int count);
    logic signed [31:0] sr, si;
    longint unsigned target;
    write_scale(h);
    for (int n = 0; n < count; n++) begin
      sr = rand_part();
      si = rand_part();
      if (h != 0 && $urandom_range(0, 3) == 0) begin
        target = (64'd1 << 46) / h;
        if (target < 64'h8000_0000) begin
          sr = 32'(target) + $signed(32'($urandom_range(0, 8))) - 32'sd4;
          si = $signed($urandom()) >>> $urandom_range(16, 31);
        end
      end
      send_root(sr, si, $urandom_range(0, 15) == 0, $urandom_range(0, 1));
    end
  endtask

  task automatic test_scale_sweep();
    test_random_roots(32'h0000_0000, 150);
    test_random_roots(32'hFFFF_FFFF, 150);
    test_random_roots(32'h0000_0001, 150);
    test_random_roots(SCALE_HALF, 250);
    for (int k = 0; k < 6; k++)
      test_random_roots($urandom() >> $urandom_range(0, 24), 175);
  endtask

  // Result checker with a receiver that switches between stall patterns.
  always @(posedge clk) begin
    int mode_left;
    int mode;
    zroot_t want;
    if (!rst) begin
      if (zroots.valid && zroots.ready) begin
        if (mapped_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected beat: re=%h im=%h ovf=%b", zroots.digital_real,
                     zroots.digital_imag, zroots.overflow);
        end else begin
          want = mapped_q.pop_front();
          if (zroots.digital_real !== want.re || zroots.digital_imag !== want.im ||
              zroots.overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected re=%h im=%h ovf=%b, got re=%h im=%h ovf=%b",
                       want.re, want.im, want.ovf, zroots.digital_real,
                       zroots.digital_imag, zroots.overflow);
          end
        end
      end
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: zroots.ready <= 1'b1;
        1: zroots.ready <= $urandom_range(0, 1);
        default: zroots.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((roots.valid && roots.ready) || (zroots.valid && zroots.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** bilinear_root_mapper_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    scale = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_scale_sweep();
    drain();
    if (mismatches == 0) begin
      $display("** bilinear_root_mapper_core: PASSED **");
    end else begin
      $display("** bilinear_root_mapper_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/brm_pkg.sv
rtl/brm_ifs.sv
rtl/brm_scale.sv
rtl/brm_square.sv
rtl/brm_divider.sv
rtl/bilinear_root_mapper_core.sv
dv/tb_bilinear_root_mapper_core.sv
